// ===== rtl/etd_pkg.sv =====
// Shared types and constants for the Euler totient trial-division core.
// Used by the controller, the datapath and the divider. No dependencies.
`default_nettype none

package etd_pkg;

   // Width of the input integer and of the totient.
   localparam int VALUE_BITS = 31;

   // The divider produces one quotient bit per cycle.
   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

   typedef logic [VALUE_BITS-1:0] value_type;

   // Operand selection for the shared divider.
   typedef enum logic [1:0] {
      DIV_REM_BY_D,
      DIV_ACC_BY_D,
      DIV_ACC_BY_REM
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        acc_scale;
      logic        rem_take_quot;
      logic        d_inc;
   } etd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic d_le_quot;
      logic rem_zero;
      logic rem_gt_one;
   } etd_status_type;

endpackage

`default_nettype wire

// ===== rtl/etd_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on etd_pkg for the value width and step count.
`default_nettype none

module etd_divider (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire etd_pkg::value_type dividend,
   input  wire etd_pkg::value_type divisor,
   output logic                 done,
   output etd_pkg::value_type   quotient,
   output etd_pkg::value_type   remainder,
   output etd_pkg::value_type   divisor_held
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   etd_pkg::value_type            quot_ff, quot_in;
   etd_pkg::value_type            rem_ff, rem_in;
   etd_pkg::value_type            divisor_ff, divisor_in;
   logic [etd_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [etd_pkg::VALUE_BITS:0]  shifted;
   logic [etd_pkg::VALUE_BITS:0]  diff;

   // One restoring step: shift in the next dividend bit and try the subtraction.
   assign shifted = {rem_ff, quot_ff[etd_pkg::VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      if (start) begin
         busy_in    = 1'b1;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = '0;
      end else if (busy_ff) begin
         if (diff[etd_pkg::VALUE_BITS]) begin
            rem_in  = shifted[etd_pkg::VALUE_BITS-1:0];
            quot_in = {quot_ff[etd_pkg::VALUE_BITS-2:0], 1'b0};
         end else begin
            rem_in  = diff[etd_pkg::VALUE_BITS-1:0];
            quot_in = {quot_ff[etd_pkg::VALUE_BITS-2:0], 1'b1};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == etd_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags are reset; the operand registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
   end

   assign done         = done_ff;
   assign quotient     = quot_ff;
   assign remainder    = rem_ff;
   assign divisor_held = divisor_ff;

endmodule

`default_nettype wire

// ===== rtl/etd_datapath.sv =====
// Datapath: result, remainder and trial divisor registers, the shared divider
// and the scaling multiplier. Depends on etd_pkg and etd_divider.
`default_nettype none

module etd_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire etd_pkg::value_type    number,
   input  wire etd_pkg::etd_cmd_type  cmd,
   output etd_pkg::etd_status_type    status,
   output etd_pkg::value_type         totient
);

   etd_pkg::value_type                acc_ff, acc_in;
   etd_pkg::value_type                rem_ff, rem_in;
   etd_pkg::value_type                d_ff, d_in;
   etd_pkg::value_type                dividend;
   etd_pkg::value_type                divisor;
   etd_pkg::value_type                quot;
   etd_pkg::value_type                div_rem;
   etd_pkg::value_type                div_divisor;
   etd_pkg::value_type                factor_m1;
   etd_pkg::value_type                product;
   logic                              div_done;

   // Operand selection for the shared divider.
   always_comb begin
      case (cmd.div_sel)
         etd_pkg::DIV_REM_BY_D: begin
            dividend = rem_ff;
            divisor  = d_ff;
         end
         etd_pkg::DIV_ACC_BY_D: begin
            dividend = acc_ff;
            divisor  = d_ff;
         end
         etd_pkg::DIV_ACC_BY_REM: begin
            dividend = acc_ff;
            divisor  = rem_ff;
         end
         default: begin
            dividend = rem_ff;
            divisor  = d_ff;
         end
      endcase
   end

   etd_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.div_start),
      .dividend     (dividend),
      .divisor      (divisor),
      .done         (div_done),
      .quotient     (quot),
      .remainder    (div_rem),
      .divisor_held (div_divisor)
   );

   // The quotient is exact, so acc / p * (p - 1) fits the value width.
   assign factor_m1 = div_divisor - etd_pkg::value_type'(1);
   assign product   = quot * factor_m1;

   // Register updates requested by the controller.
   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      d_in   = d_ff;
      if (cmd.load) begin
         acc_in = number;
         rem_in = number;
         d_in   = etd_pkg::value_type'(2);
      end else begin
         if (cmd.acc_scale) begin
            acc_in = product;
         end
         if (cmd.rem_take_quot) begin
            rem_in = quot;
         end
         if (cmd.d_inc) begin
            d_in = d_ff + etd_pkg::value_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign status.div_done   = div_done;
   assign status.d_le_quot  = (d_ff <= quot);
   assign status.rem_zero   = (div_rem == '0);
   assign status.rem_gt_one = (rem_ff > etd_pkg::value_type'(1));
   assign totient           = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/etd_ctrl.sv =====
// Controller state machine that sequences trial divisions and scaling.
// Depends on etd_pkg for the command and status types.
`default_nettype none

module etd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire etd_pkg::etd_status_type status,
   output etd_pkg::etd_cmd_type         cmd,
   output logic                         busy,
   output logic                         rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIAL,
      ST_TRIAL_WAIT,
      ST_ACC_WAIT,
      ST_STRIP,
      ST_STRIP_WAIT,
      ST_FINAL_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      cmd.div_sel = etd_pkg::DIV_REM_BY_D;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            cmd.div_start = 1'b1;
            state_in      = ST_TRIAL_WAIT;
         end
         ST_TRIAL_WAIT: begin
            if (status.div_done) begin
               if (!status.d_le_quot) begin
                  // Divisor squared exceeds the remainder: the trial phase is over.
                  if (status.rem_gt_one) begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = etd_pkg::DIV_ACC_BY_REM;
                     state_in      = ST_FINAL_WAIT;
                  end else begin
                     busy_in   = 1'b0;
                     strobe_in = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end else if (status.rem_zero) begin
                  cmd.rem_take_quot = 1'b1;
                  cmd.div_start     = 1'b1;
                  cmd.div_sel       = etd_pkg::DIV_ACC_BY_D;
                  state_in          = ST_ACC_WAIT;
               end else begin
                  cmd.d_inc = 1'b1;
                  state_in  = ST_TRIAL;
               end
            end
         end
         ST_ACC_WAIT: begin
            if (status.div_done) begin
               cmd.acc_scale = 1'b1;
               state_in      = ST_STRIP;
            end
         end
         ST_STRIP: begin
            cmd.div_start = 1'b1;
            state_in      = ST_STRIP_WAIT;
         end
         ST_STRIP_WAIT: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.rem_take_quot = 1'b1;
                  state_in          = ST_STRIP;
               end else begin
                  cmd.d_inc = 1'b1;
                  state_in  = ST_TRIAL;
               end
            end
         end
         ST_FINAL_WAIT: begin
            if (status.div_done) begin
               cmd.acc_scale = 1'b1;
               busy_in       = 1'b0;
               strobe_in     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== rtl/euler_totient_trial_division_core.sv =====
// Top level of the Euler totient core: controller plus datapath.
// Depends on etd_pkg, etd_ctrl, etd_datapath and etd_divider.
// Each trial divisor costs one serial divide of VALUE_BITS steps plus the
// ST_TRIAL and ST_TRIAL_WAIT control states. A prime factor found adds a divide
// to scale the result and one per power of it; a last prime factor adds one
// more. A prime near 2^31 needs about 46340 trial divisors. One item at a
// time; the next transfer is taken in the cycle of the result strobe, when busy
// has fallen. Results cannot be held off. Synchronous active-high reset idles.
`default_nettype none

module euler_totient_trial_division_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire etd_pkg::value_type req_number,
   output logic                    rsp_strobe,
   output etd_pkg::value_type      rsp_totient
);

   etd_pkg::etd_cmd_type    cmd;
   etd_pkg::etd_status_type status;

   etd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   etd_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .number  (req_number),
      .cmd     (cmd),
      .status  (status),
      .totient (rsp_totient)
   );

endmodule

`default_nettype wire

// ===== rtl/etd_checker.sv =====
// Port-level checks for the Euler totient core, attached with a bind.
// Depends on etd_pkg and on euler_totient_trial_division_core.
`default_nettype none

module etd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire etd_pkg::value_type req_number,
   input wire logic               rsp_strobe,
   input wire etd_pkg::value_type rsp_totient
);

   etd_pkg::value_type last_number_ff;

   // Hold the number of the transfer in progress.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         last_number_ff <= req_number;
      end
   end

   // An accepted transfer makes the core busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a transfer");

   // A result only ends a busy period.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a job in progress");

   // The end of a busy period always delivers its result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a result");

   // The totient never exceeds the number it was taken of.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_totient <= last_number_ff))
      else $error("totient larger than its number");

endmodule

bind euler_totient_trial_division_core etd_checker u_etd_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_number  (req_number),
   .rsp_strobe  (rsp_strobe),
   .rsp_totient (rsp_totient)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for euler_totient_trial_division_core.
// Depends on etd_pkg and the core; drives directed and random integers and
// checks every totient against a predictor built into this file.
`default_nettype none

module tb;

   // A row of the directed table: the expected totient is typed in only where
   // it is obvious, otherwise the predictor supplies it.
   typedef struct {
      etd_pkg::value_type number;
      bit                 typed;
      etd_pkg::value_type totient;
   } number_row_type;

   localparam int NUM_DIRECTED = 20;
   localparam longint unsigned NUMBER_MAX = (64'd1 << etd_pkg::VALUE_BITS) - 1;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   etd_pkg::value_type req_number;
   logic               rsp_strobe;
   etd_pkg::value_type rsp_totient;

   etd_pkg::value_type totient_q[$];
   etd_pkg::value_type number_q[$];
   int                 errors = 0;

   number_row_type number_table[NUM_DIRECTED] = '{
      '{31'd0,          1'b1, 31'd0},
      '{31'd1,          1'b1, 31'd1},
      '{31'd2,          1'b1, 31'd1},
      '{31'h7FFFFFFF,   1'b1, 31'h7FFFFFFE},
      '{31'h40000000,   1'b1, 31'h20000000},
      '{31'd3,          1'b0, 31'd0},
      '{31'd4,          1'b0, 31'd0},
      '{31'd6,          1'b0, 31'd0},
      '{31'd12,         1'b0, 31'd0},
      '{31'd36,         1'b0, 31'd0},
      '{31'd97,         1'b0, 31'd0},
      '{31'd961,        1'b0, 31'd0},
      '{31'd4096,       1'b0, 31'd0},
      '{31'd10403,      1'b0, 31'd0},
      '{31'd510510,     1'b0, 31'd0},
      '{31'd1234567,    1'b0, 31'd0},
      '{31'd1000003,    1'b0, 31'd0},
      '{31'h55555555,   1'b0, 31'd0},
      '{31'h2AAAAAAA,   1'b0, 31'd0},
      '{31'h7FFFFFFE,   1'b0, 31'd0}
   };

   int unsigned small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

   euler_totient_trial_division_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_number  (req_number),
      .rsp_strobe  (rsp_strobe),
      .rsp_totient (rsp_totient)
   );

   // Free-running clock with a period of 10 time units.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Totient by trial division; the square test is made as d <= rem / d.
   function automatic etd_pkg::value_type totient_of(input etd_pkg::value_type number);
      longint unsigned acc;
      longint unsigned rem;
      longint unsigned d;
      acc = number;
      rem = number;
      if (rem == 0) begin
         return '0;
      end
      for (d = 2; d <= rem / d; d++) begin
         if (rem % d == 0) begin
            acc = acc / d * (d - 1);
            while (rem % d == 0) begin
               rem = rem / d;
            end
         end
      end
      if (rem > 1) begin
         acc = acc / rem * (rem - 1);
      end
      return etd_pkg::value_type'(acc);
   endfunction

   // A product of small primes close to the top of the range: high bits set,
   // yet few trial divisors, so the core finishes it quickly.
   function automatic etd_pkg::value_type smooth_number();
      longint unsigned n;
      longint unsigned p;
      n = 1;
      repeat (40) begin
         p = small_primes[$urandom_range(10)];
         if (n * p <= NUMBER_MAX) begin
            n = n * p;
         end
      end
      return etd_pkg::value_type'(n);
   endfunction

   // Present one integer, optionally after an idle gap, and hold it until the
   // core takes it; the expected totient is queued at that edge.
   task automatic transfer_number(input etd_pkg::value_type number,
                                  input etd_pkg::value_type totient,
                                  input int idle_pct);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(6, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_number <= number;
      start      <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      totient_q = {totient_q, totient};
      number_q  = {number_q, number};
   endtask

   // Hold the sender off until every expected totient has arrived.
   task automatic wait_until_drained();
      start <= 1'b0;
      while (totient_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Result checking: each strobe is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (totient_q.size() == 0) begin
            if (errors < 10) begin
               $display("Unexpected totient %0d with no transfer outstanding", rsp_totient);
            end
            errors = errors + 1;
         end else begin
            if (rsp_totient !== totient_q[0]) begin
               if (errors < 10) begin
                  $display("Totient mismatch for %0d: expected %0d, got %0d",
                           number_q[0], totient_q[0], rsp_totient);
               end
               errors = errors + 1;
            end
            void'(totient_q.pop_front());
            void'(number_q.pop_front());
         end
      end
   end

   // Stimulus: directed table first, then random phases with varied idling.
   initial begin
      int                 idle_pcts[3] = '{0, 65, 21};
      int                 pick;
      etd_pkg::value_type number;
      reset      = 1'b1;
      start      = 1'b0;
      req_number = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         transfer_number(number_table[i].number,
                         number_table[i].typed ? number_table[i].totient
                                               : totient_of(number_table[i].number),
                         0);
      end
      wait_until_drained();

      // Mostly small integers; a few mid-sized ones and smooth large ones.
      foreach (idle_pcts[ph]) begin
         for (int i = 0; i < 34; i++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               number = etd_pkg::value_type'($urandom_range(4095, 1));
            end else if (pick < 85) begin
               number = etd_pkg::value_type'($urandom_range(1048575, 1));
            end else begin
               number = smooth_number();
            end
            transfer_number(number, totient_of(number), idle_pcts[ph]);
         end
         wait_until_drained();
      end

      // Allow a stray strobe to show up before the verdict.
      repeat (100) @(posedge clock);
      if (errors == 0 && totient_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #200000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
